// ===== design/frc_pkg.sv =====
// Shared types and constants for the frame change run finder.
// Used by frc_run_track and frame_change_run_finder_core; no dependencies.
package frc_pkg;

  localparam int unsigned MaxWidth  = 512;
  localparam int unsigned MaxHeight = 512;

  localparam int unsigned PixW    = 16;
  localparam int unsigned DimW    = 10;
  localparam int unsigned ColW    = 9;
  localparam int unsigned RowW    = 9;
  localparam int unsigned MaxRunW = 13;
  localparam int unsigned RunLenW = 12;
  localparam int unsigned RunNumW = 18;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 13;

  localparam logic [DimW-1:0]    FrameWidthRst  = DimW'(480);
  localparam logic [DimW-1:0]    FrameHeightRst = DimW'(320);
  localparam logic [MaxRunW-1:0] MaxRunRst      = MaxRunW'(101);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MAX_RUN      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DimW-1:0]    frame_width;
    logic [DimW-1:0]    frame_height;
    logic [MaxRunW-1:0] max_run_pixels;
  } cfg_t;

  typedef struct packed {
    logic [RowW-1:0]    row;
    logic [ColW-1:0]    first_col;
    logic [ColW-1:0]    last_col;
    logic [RunNumW-1:0] number;
    logic               frame_done;
  } run_desc_t;

  // Last usable index for a dimension: zero acts as one, large values saturate.
  function automatic logic [ColW-1:0] dim_last(logic [DimW-1:0] dim, int unsigned max_dim);
    logic [ColW-1:0] res;
    if (dim == '0) begin
      res = '0;
    end else if (32'(dim) > max_dim) begin
      res = ColW'(max_dim - 1);
    end else begin
      res = ColW'(dim - DimW'(1));
    end
    return res;
  endfunction

endpackage

// ===== design/frc_run_track.sv =====
// Position counters and run detection for the frame change run finder.
// Depends on frc_pkg; one request is processed per step_i pulse.
module frc_run_track import frc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic      changed_i,
  input  cfg_t      cfg_i,
  output logic      emit_o,
  output run_desc_t res_o
);

  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic               open_q, open_d;
  logic [ColW-1:0]    start_q, start_d;
  logic [RunLenW-1:0] len_q, len_d;
  logic [RunNumW-1:0] runs_q, runs_d;

  logic [ColW-1:0] w_last;
  logic [RowW-1:0] h_last;
  logic            last_col;
  logic            last_row;
  logic            emit;
  logic [ColW-1:0] first_sel;
  logic [ColW-1:0] last_sel;

  assign w_last   = dim_last(cfg_i.frame_width, MaxWidth);
  assign h_last   = RowW'(dim_last(cfg_i.frame_height, MaxHeight));
  assign last_col = col_q >= w_last;
  assign last_row = row_q >= h_last;

  always_comb begin
    open_d    = open_q;
    start_d   = start_q;
    len_d     = len_q;
    runs_d    = runs_q;
    emit      = 1'b0;
    first_sel = start_q;
    last_sel  = col_q;

    if (changed_i) begin
      if (!open_q) begin
        open_d  = 1'b1;
        start_d = col_q;
        len_d   = RunLenW'(1);
      end else begin
        len_d = len_q + RunLenW'(1);
      end
      if ({1'b0, len_d} == cfg_i.max_run_pixels) begin
        emit      = 1'b1;
        first_sel = start_d;
        last_sel  = col_q;
        open_d    = 1'b0;
      end
    end else if (open_q) begin
      // An unchanged pixel ends the run on the previous column.
      emit      = 1'b1;
      first_sel = start_q;
      last_sel  = (col_q == '0) ? '0 : col_q - ColW'(1);
      open_d    = 1'b0;
    end

    // Runs never cross the end of a row.
    if (open_d && last_col) begin
      emit      = 1'b1;
      first_sel = start_d;
      last_sel  = col_q;
      open_d    = 1'b0;
    end

    if (emit) begin
      len_d  = '0;
      runs_d = runs_q + RunNumW'(1);
    end

    if (last_col) begin
      col_d = '0;
      if (last_row) begin
        row_d  = '0;
        runs_d = '0;
      end else begin
        row_d = row_q + RowW'(1);
      end
    end else begin
      col_d = col_q + ColW'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      open_q  <= 1'b0;
      start_q <= '0;
      len_q   <= '0;
      runs_q  <= '0;
    end else if (step_i) begin
      col_q   <= col_d;
      row_q   <= row_d;
      open_q  <= open_d;
      start_q <= start_d;
      len_q   <= len_d;
      runs_q  <= runs_d;
    end
  end

  assign emit_o           = emit;
  assign res_o.row        = row_q;
  assign res_o.first_col  = first_sel;
  assign res_o.last_col   = last_sel;
  assign res_o.number     = runs_q;
  assign res_o.frame_done = last_col && last_row;

`ifndef SYNTH
  a_start_behind_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> start_q <= col_q)
    else $error("open run starts beyond the current column");

  a_open_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> len_q != '0)
    else $error("open run has zero length");

  a_run_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && emit) |-> res_o.last_col >= res_o.first_col)
    else $error("run ends before it starts");
`endif

endmodule

// ===== design/frame_change_run_finder_core.sv =====
// Top level of the frame change run finder: config registers, input stage,
// run tracking (frc_run_track) and a two-entry result buffer. Depends on frc_pkg.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+----------------------------------------------
//   in      | in_valid_i  | in_ready_o  | old_pixel_i, new_pixel_i
//   out     | out_valid_o | out_ready_i | run_row_o, run_first_col_o, run_last_col_o,
//           |             |             | run_number_o, frame_done_o
//   cfg     | cfg_valid_i | cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel pair is taken per cycle unless the input stage is full and the skid entry
// is occupied. The compare is registered, then the tracker and the result buffer
// form the second stage. The two-entry result buffer lets input continue
// for one result while the output is stalled. Reset clears position and run state
// and loads 480 x 320 with a run limit of 101. Config is always ready.
module frame_change_run_finder_core import frc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     old_pixel_i,
  input  logic [PixW-1:0]     new_pixel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RowW-1:0]     run_row_o,
  output logic [ColW-1:0]     run_first_col_o,
  output logic [ColW-1:0]     run_last_col_o,
  output logic [RunNumW-1:0]  run_number_o,
  output logic                frame_done_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDatW-1:0]  cfg_data_i
);

  cfg_t      cfg_q;
  logic      in_valid_q;
  logic      changed_q;
  logic      out_valid_q;
  logic      skid_valid_q;
  run_desc_t out_q;
  run_desc_t skid_q;

  logic      in_take;
  logic      step;
  logic      emit;
  logic      push;
  logic      pop;
  run_desc_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= FrameWidthRst;
      cfg_q.frame_height   <= FrameHeightRst;
      cfg_q.max_run_pixels <= MaxRunRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  cfg_q.frame_width    <= cfg_data_i[DimW-1:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height   <= cfg_data_i[DimW-1:0];
        CFG_MAX_RUN:      cfg_q.max_run_pixels <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The second stage advances whenever the input stage holds a pair and the skid entry is free.
  assign step       = in_valid_q && !skid_valid_q;
  assign in_ready_o = !in_valid_q || !skid_valid_q;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      changed_q <= old_pixel_i != new_pixel_i;
    end
  end

  frc_run_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .changed_i (changed_q),
    .cfg_i     (cfg_q),
    .emit_o    (emit),
    .res_o     (res)
  );

  assign push = step && emit;
  assign pop  = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign run_row_o       = out_q.row;
  assign run_first_col_o = out_q.first_col;
  assign run_last_col_o  = out_q.last_col;
  assign run_number_o    = out_q.number;
  assign frame_done_o    = out_q.frame_done;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output entry is empty");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(out_q))
    else $error("stalled result changed or vanished");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && skid_valid_q) |=> in_valid_q && $stable(changed_q))
    else $error("input stage lost a request while the buffer was full");
`endif

endmodule
